>>> hdl/adx_pkg.sv
// Shared types, constants and helper functions of the ADX ADPCM block decoder.
package adx_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SLOT_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_W         = 3;
    localparam int BYTE_W       = 8;
    localparam int SMP_W        = 16;
    localparam int SCALE_W      = 17;
    localparam int NIB_W        = 4;
    localparam int K_W          = NIB_W + SCALE_W;
    localparam int C1_W         = 14;
    localparam int C2_W         = 13;
    localparam int FRAC_W       = 12;
    localparam int POS_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TWO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd2;

    localparam logic [POS_W-1:0] BLOCK_BYTES_RST = 8'd18;
    localparam logic [POS_W-1:0] MIN_BLOCK_BYTES = 8'd3;
    localparam logic [POS_W-1:0] POS_SCALE_HI    = 8'd0;
    localparam logic [POS_W-1:0] POS_SCALE_LO    = 8'd1;

    typedef logic signed [SMP_W-1:0] t_smp;
    typedef logic signed [K_W-1:0]   t_kval;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [CH_W-1:0]   channel;
    } t_in_beat;

    typedef struct packed {
        t_smp            sample;
        logic [CH_W-1:0] sample_channel;
        logic            last;
        logic            block_end;
    } t_out_beat;

    // One data byte handed from the fetch stage to the predictor.
    typedef struct packed {
        logic              vld;
        logic [CH_W-1:0]   chin;
        logic [SLOT_W-1:0] slot;
        logic              blk_end;
        t_smp              h1;
        t_smp              h2;
        t_kval             k_hi;
        t_kval             k_lo;
    } t_load;

    // History write-back of a finished byte.
    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
        t_smp              s0;
        t_smp              s1;
    } t_wb;

    // Channel number folded onto the history entries.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_W-1:0] ch);
        logic [SLOT_W-1:0] s;
        s = '0;
        for (int i = 0; i < (1 << CH_W); i++) begin
            if (ch == CH_W'(i)) begin
                s = SLOT_W'(i % MAX_CHANNELS);
            end
        end
        return s;
    endfunction

endpackage

>>> hdl/adx_in_if.sv
// Input channel: one byte of a block with its channel number.
interface adx_in_if;
    import adx_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hdl/adx_out_if.sv
// Output channel: one decoded sample with its tags.
interface adx_out_if;
    import adx_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hdl/adx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module adx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/adx_predict.sv
// Predictor unit: two chained sample steps per byte, output register and history write-back.
module adx_predict (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [adx_pkg::C1_W-1:0]         i_coef_one,
    input  logic signed [adx_pkg::C2_W-1:0]  i_coef_two,
    input  adx_pkg::t_load                   i_load,
    output logic                             o_take,
    output adx_pkg::t_wb                     o_wb,
    adx_out_if.source                        o_out
);
    import adx_pkg::*;

    localparam int SUM_W = SMP_W + C1_W + 5;
    localparam int Q_W   = SUM_W - FRAC_W;
    localparam int P1_W  = SMP_W + C1_W + 1;
    localparam int P2_W  = SMP_W + C2_W;

    logic              r_b_vld;
    logic              r_b_ph;
    logic [CH_W-1:0]   r_b_chin;
    logic [SLOT_W-1:0] r_b_slot;
    logic              r_b_end;
    t_smp              r_b_h1;
    t_smp              r_b_h2;
    t_kval             r_b_k_hi;
    t_kval             r_b_k_lo;

    logic              r_o_vld;
    t_out_beat         r_o_data;

    logic                           out_free;
    logic                           step;
    logic                           b_free;
    t_kval                          k_cur;
    logic signed [P1_W-1:0]         p_one;
    logic signed [P2_W-1:0]         p_two;
    logic signed [K_W+FRAC_W-1:0]   p_nib;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SUM_W-1:0]        adj;
    logic signed [Q_W-1:0]          q;
    t_smp                           s_new;

    assign out_free = !r_o_vld || o_out.ready;
    assign step     = r_b_vld && out_free;
    assign b_free   = !r_b_vld || (r_b_ph && out_free);
    assign o_take   = i_load.vld && b_free;

    // Sum of both predictor taps and the scaled nibble, truncated toward zero and saturated.
    always_comb begin
        k_cur = r_b_ph ? r_b_k_lo : r_b_k_hi;
        p_one = P1_W'($signed({1'b0, i_coef_one})) * P1_W'(r_b_h1);
        p_two = P2_W'(i_coef_two) * P2_W'(r_b_h2);
        p_nib = {k_cur, {FRAC_W{1'b0}}};
        sum   = SUM_W'(p_one) + SUM_W'(p_two) + SUM_W'(p_nib);
        adj   = sum + (sum[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
        q     = adj[SUM_W-1:FRAC_W];
        if (!q[Q_W-1] && (|q[Q_W-2:SMP_W-1])) begin
            s_new = {1'b0, {(SMP_W-1){1'b1}}};
        end else if (q[Q_W-1] && !(&q[Q_W-2:SMP_W-1])) begin
            s_new = {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            s_new = q[SMP_W-1:0];
        end
    end

    always_comb begin
        o_wb.vld  = step && r_b_ph;
        o_wb.slot = r_b_slot;
        o_wb.s0   = r_b_h1;
        o_wb.s1   = s_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_b_ph  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_b_vld <= 1'b1;
                r_b_ph  <= 1'b0;
            end else if (step && r_b_ph) begin
                r_b_vld <= 1'b0;
                r_b_ph  <= 1'b0;
            end else if (step) begin
                r_b_ph <= 1'b1;
            end
            if (step) begin
                r_o_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_b_chin <= i_load.chin;
            r_b_slot <= i_load.slot;
            r_b_end  <= i_load.blk_end;
            r_b_h1   <= i_load.h1;
            r_b_h2   <= i_load.h2;
            r_b_k_hi <= i_load.k_hi;
            r_b_k_lo <= i_load.k_lo;
        end else if (step && !r_b_ph) begin
            // The first sample becomes the newest history for the second step.
            r_b_h2 <= r_b_h1;
            r_b_h1 <= s_new;
        end
        if (step) begin
            r_o_data.sample         <= s_new;
            r_o_data.sample_channel <= r_b_chin;
            r_o_data.last           <= r_b_ph;
            r_o_data.block_end      <= r_b_ph && r_b_end;
        end
    end

    assign o_out.valid = r_o_vld;
    assign o_out.data  = r_o_data;

    ap_second_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !r_b_ph) |=> (r_b_vld && r_b_ph))
        else $error("high-nibble sample not followed by the low-nibble step");

    ap_wb_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wb.vld |=> (r_o_vld && r_o_data.last))
        else $error("history written back without a low-nibble sample beat");

    ap_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_data.block_end) |-> r_o_data.last)
        else $error("block end flagged on a high-nibble sample");

    ap_load_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> (r_b_vld && !r_b_ph))
        else $error("loaded byte does not start at the high-nibble step");
endmodule

>>> hdl/adx_adpcm_block_decoder.sv
// Top level of the ADX ADPCM block decoder: block framing, history memory and fetch stage.
//
//  port        dir   beat content
//  i_in        in    data_byte[7:0], channel[2:0]
//  o_out       out   sample[15:0] signed, sample_channel[2:0], last, block_end
//  i_cfg_*     in    write enable, register index [1:0], data [13:0]
//
// A data byte takes two predictor steps, one per sample, since the second sample feeds on the
// first; a data byte is taken as the last one's second step runs, and scale bytes one a cycle
// unless a waiting byte holds the input. Samples pass the fetch, byte and output registers.
// Reset returns the coefficients, block length, framing and all channel histories to their
// initial values at once; the eight history entries carry valid bits, so no clearing pass runs.
// A stalled output holds the predictor; one byte still waits in the fetch stage meanwhile.
module adx_adpcm_block_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [adx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [adx_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    adx_in_if.sink                            i_in,
    adx_out_if.source                         o_out
);
    import adx_pkg::*;

    logic [C1_W-1:0]           r_coef_one;
    logic signed [C2_W-1:0]    r_coef_two;
    logic [POS_W-1:0]          r_block_bytes;
    logic [POS_W-1:0]          r_pos;
    logic [BYTE_W-1:0]         r_scale_hi;
    logic signed [SCALE_W-1:0] r_scale;

    logic                      r_a_vld;
    logic [BYTE_W-1:0]         r_a_byte;
    logic [CH_W-1:0]           r_a_chin;
    logic [SLOT_W-1:0]         r_a_slot;
    logic                      r_a_end;
    logic signed [SCALE_W-1:0] r_a_scale;

    logic [MAX_CHANNELS-1:0]   r_slot_vld;
    logic                      r_rd_ok;
    t_wb                       r_wb;

    logic                      in_acc;
    logic                      data_acc;
    logic [POS_W-1:0]          blk_len;
    logic [POS_W:0]            pos_inc;
    logic                      is_end;
    logic [SLOT_W-1:0]         in_slot;
    logic [SLOT_W-1:0]         rd_slot;
    logic [2*SMP_W-1:0]        rd_data;
    t_load                     load;
    t_wb                       wb;
    logic                      a_take;

    assign in_acc   = i_in.valid && i_in.ready;
    assign data_acc = in_acc && (r_pos != POS_SCALE_HI) && (r_pos != POS_SCALE_LO);
    assign blk_len  = (r_block_bytes < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : r_block_bytes;
    assign pos_inc  = {1'b0, r_pos} + (POS_W+1)'(1);
    assign is_end   = pos_inc >= {1'b0, blk_len};
    assign in_slot  = slot_of(i_in.data.channel);
    assign i_in.ready = !r_a_vld || a_take;

    // The fetch stage re-reads its entry every cycle it waits.
    assign rd_slot = in_acc ? in_slot : r_a_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_one    <= '0;
            r_coef_two    <= '0;
            r_block_bytes <= BLOCK_BYTES_RST;
            r_pos         <= POS_SCALE_HI;
            r_scale_hi    <= '0;
            r_scale       <= '0;
            r_a_vld       <= 1'b0;
            r_slot_vld    <= '0;
            r_rd_ok       <= 1'b0;
            r_wb.vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COEF_ONE:    r_coef_one    <= i_cfg_data[C1_W-1:0];
                    CFG_COEF_TWO:    r_coef_two    <= i_cfg_data[C2_W-1:0];
                    CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[POS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                priority if (r_pos == POS_SCALE_HI) begin
                    r_scale_hi <= i_in.data.data_byte;
                    r_pos      <= POS_SCALE_LO;
                end else if (r_pos == POS_SCALE_LO) begin
                    // The stored scale is one less than the real one.
                    r_scale <= SCALE_W'($signed({r_scale_hi, i_in.data.data_byte}))
                             + SCALE_W'(1);
                    r_pos   <= r_pos + POS_W'(1);
                end else begin
                    r_pos <= is_end ? POS_SCALE_HI : pos_inc[POS_W-1:0];
                end
            end
            if (data_acc) begin
                r_a_vld <= 1'b1;
            end else if (a_take) begin
                r_a_vld <= 1'b0;
            end
            if (wb.vld) begin
                r_slot_vld[wb.slot] <= 1'b1;
            end
            r_rd_ok   <= r_slot_vld[rd_slot];
            r_wb.vld  <= wb.vld;
            r_wb.slot <= wb.slot;
            r_wb.s0   <= wb.s0;
            r_wb.s1   <= wb.s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_a_byte  <= i_in.data.data_byte;
            r_a_chin  <= i_in.data.channel;
            r_a_slot  <= in_slot;
            r_a_end   <= is_end;
            r_a_scale <= r_scale;
        end
    end

    // History of the waiting byte: write-back of this cycle first, then that of the
    // last cycle, which the memory read has not seen yet, then the memory itself, else zero.
    always_comb begin
        load.vld     = r_a_vld;
        load.chin    = r_a_chin;
        load.slot    = r_a_slot;
        load.blk_end = r_a_end;
        load.k_hi    = K_W'($signed(r_a_byte[BYTE_W-1:NIB_W])) * K_W'(r_a_scale);
        load.k_lo    = K_W'($signed(r_a_byte[NIB_W-1:0])) * K_W'(r_a_scale);
        priority if (wb.vld && (wb.slot == r_a_slot)) begin
            load.h1 = wb.s1;
            load.h2 = wb.s0;
        end else if (r_wb.vld && (r_wb.slot == r_a_slot)) begin
            load.h1 = r_wb.s1;
            load.h2 = r_wb.s0;
        end else if (r_rd_ok) begin
            load.h1 = rd_data[2*SMP_W-1:SMP_W];
            load.h2 = rd_data[SMP_W-1:0];
        end else begin
            load.h1 = '0;
            load.h2 = '0;
        end
    end

    adx_ram #(
        .WIDTH(2 * SMP_W),
        .DEPTH(MAX_CHANNELS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (wb.vld),
        .i_waddr (wb.slot),
        .i_wdata ({wb.s1, wb.s0}),
        .i_raddr (rd_slot),
        .o_rdata (rd_data)
    );

    adx_predict u_predict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef_one (r_coef_one),
        .i_coef_two (r_coef_two),
        .i_load     (load),
        .o_take     (a_take),
        .o_wb       (wb),
        .o_out      (o_out)
    );
endmodule
